FILE: sv/rtsr_pkg.sv
// Package for the rigid transform surface residual block.
// Holds widths, register indexes, the side-data struct and saturation.
// No dependencies.
package rtsr_pkg;

  localparam int COORD_W = 32;
  localparam int TRIG_W  = 18;
  localparam int EXT_W   = 40;
  localparam int QB      = 30;
  localparam int IDX_W   = 4;
  localparam int DATA_W  = 32;
  localparam int FOCAL_W = 31;

  typedef enum logic [IDX_W-1:0] {
    CFG_COS_YAW   = 4'd0,
    CFG_SIN_YAW   = 4'd1,
    CFG_COS_PITCH = 4'd2,
    CFG_SIN_PITCH = 4'd3,
    CFG_SHIFT_X   = 4'd4,
    CFG_SHIFT_Y   = 4'd5,
    CFG_SHIFT_Z   = 4'd6,
    CFG_FOCAL     = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic                    outside;
    logic [COORD_W-1:0]      mx;
    logic [COORD_W-1:0]      my;
    logic signed [EXT_W-1:0] z2;
  } side_t;

  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    hi = EXT_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
    lo = -hi - EXT_W'(1);
    if (v > hi) begin
      sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v < lo) begin
      sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat_coord = v[COORD_W-1:0];
    end
  endfunction

endpackage

FILE: sv/rigid_transform_surface_residual.sv
// Rigid transform surface residual: rotates and shifts a Q16.16 point,
// then evaluates the surface term and the z residual.
// Depends on rtsr_pkg.
//
// Usage:
//   Input: drive point_x/y/z and raise start; a beat is taken at every
//   clock edge with start high and busy low. busy is always low, so one
//   point can enter every cycle.
//   Configuration: cfg_valid with cfg_index and cfg_data; cfg_ready is
//   always high. Indexes 0..7 select cos_yaw, sin_yaw, cos_pitch, sin_pitch,
//   shift_x, shift_y, shift_z, focal_length; other indexes are dropped.
//   Write configuration only while no point is in flight.
//   Output: done is high for one cycle with moved_x, moved_y, residual_z
//   and out_of_aperture. The pipeline holds the 31-step tau divider, the
//   31-step square root and the 30-step surface divider, one step per stage.
//   Throughput: one point per cycle.
//   Reset: clears all valid bits and loads the register defaults.
//   The receiver cannot stall; results leave in order, one per point.
module rigid_transform_surface_residual
  import rtsr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] point_z,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  output logic                     done,
  output logic signed [COORD_W-1:0] moved_x,
  output logic signed [COORD_W-1:0] moved_y,
  output logic signed [COORD_W-1:0] residual_z,
  output logic                     out_of_aperture
);

  localparam int LAT = 107;
  localparam logic [38:0] K171 = 39'(171) << QB;
  localparam logic [39:0] K47  = 40'(47) << QB;
  localparam logic [31:0] ONE32 = 32'(1) << QB;
  localparam logic [30:0] ONE31 = 31'(1) << QB;

  logic signed [TRIG_W-1:0]  cos_yaw, sin_yaw, cos_pitch, sin_pitch;
  logic signed [COORD_W-1:0] shift_x, shift_y, shift_z;
  logic [FOCAL_W-1:0]        focal_length;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_yaw      <= TRIG_W'(65536);
      sin_yaw      <= '0;
      cos_pitch    <= TRIG_W'(65536);
      sin_pitch    <= '0;
      shift_x      <= '0;
      shift_y      <= '0;
      shift_z      <= '0;
      focal_length <= FOCAL_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COS_YAW:   cos_yaw      <= cfg_data[TRIG_W-1:0];
        CFG_SIN_YAW:   sin_yaw      <= cfg_data[TRIG_W-1:0];
        CFG_COS_PITCH: cos_pitch    <= cfg_data[TRIG_W-1:0];
        CFG_SIN_PITCH: sin_pitch    <= cfg_data[TRIG_W-1:0];
        CFG_SHIFT_X:   shift_x      <= cfg_data[COORD_W-1:0];
        CFG_SHIFT_Y:   shift_y      <= cfg_data[COORD_W-1:0];
        CFG_SHIFT_Z:   shift_z      <= cfg_data[COORD_W-1:0];
        CFG_FOCAL:     focal_length <= cfg_data[FOCAL_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: pitch products
  logic signed [49:0] m_ycp, m_zsp, m_ysp, m_zcp;
  logic signed [33:0] p_ycp, p_zsp, p_ysp, p_zcp;
  logic signed [COORD_W-1:0] x_s1;
  logic v1;
  assign m_ycp = point_y * cos_pitch;
  assign m_zsp = point_z * sin_pitch;
  assign m_ysp = point_y * sin_pitch;
  assign m_zcp = point_z * cos_pitch;

  always_ff @(posedge clk) begin
    v1    <= rst ? 1'b0 : (start && !busy);
    p_ycp <= m_ycp[49:16];
    p_zsp <= m_zsp[49:16];
    p_ysp <= m_ysp[49:16];
    p_zcp <= m_zcp[49:16];
    x_s1  <= point_x;
  end

  // stage 2: pitch sums
  logic signed [34:0] y1_s2, z1_s2;
  logic signed [COORD_W-1:0] x_s2;
  logic v2;
  always_ff @(posedge clk) begin
    v2    <= rst ? 1'b0 : v1;
    y1_s2 <= 35'(p_ycp) - 35'(p_zsp);
    z1_s2 <= 35'(p_ysp) + 35'(p_zcp);
    x_s2  <= x_s1;
  end

  // stage 3: yaw products
  logic signed [49:0] m_xcy, m_xsy;
  logic signed [52:0] m_z1sy, m_z1cy;
  logic signed [33:0] a3, d3;
  logic signed [36:0] b3, c3;
  logic signed [34:0] y1_s3;
  logic v3;
  assign m_xcy  = x_s2 * cos_yaw;
  assign m_xsy  = x_s2 * sin_yaw;
  assign m_z1sy = z1_s2 * sin_yaw;
  assign m_z1cy = z1_s2 * cos_yaw;

  always_ff @(posedge clk) begin
    v3    <= rst ? 1'b0 : v2;
    a3    <= m_xcy[49:16];
    d3    <= m_xsy[49:16];
    b3    <= m_z1sy[52:16];
    c3    <= m_z1cy[52:16];
    y1_s3 <= y1_s2;
  end

  // stage 4: yaw sums and translation
  logic signed [EXT_W-1:0] x2, y2, z2;
  logic v4;
  always_ff @(posedge clk) begin
    v4 <= rst ? 1'b0 : v3;
    x2 <= EXT_W'(a3) + EXT_W'(b3) + EXT_W'(shift_x);
    y2 <= EXT_W'(y1_s3) + EXT_W'(shift_y);
    z2 <= EXT_W'(c3) - EXT_W'(d3) + EXT_W'(shift_z);
  end

  // stage 5: aperture bound, saturate moved coordinates
  logic [EXT_W-1:0] ax, ay;
  logic [FOCAL_W-1:0] ax5, ay5;
  side_t side5;
  logic v5;
  assign ax = x2[EXT_W-1] ? EXT_W'(-x2) : EXT_W'(x2);
  assign ay = y2[EXT_W-1] ? EXT_W'(-y2) : EXT_W'(y2);

  always_ff @(posedge clk) begin
    v5            <= rst ? 1'b0 : v4;
    side5.outside <= (focal_length == '0) || (ax > EXT_W'(focal_length))
                     || (ay > EXT_W'(focal_length));
    side5.mx      <= sat_coord(x2);
    side5.my      <= sat_coord(y2);
    side5.z2      <= z2;
    ax5           <= ax[FOCAL_W-1:0];
    ay5           <= ay[FOCAL_W-1:0];
  end

  // stage 6: squares
  logic [61:0] xs6, ys6, den6;
  side_t side6;
  logic v6;
  always_ff @(posedge clk) begin
    v6    <= rst ? 1'b0 : v5;
    xs6   <= 62'(ax5) * 62'(ax5);
    ys6   <= 62'(ay5) * 62'(ay5);
    den6  <= 62'(focal_length) * 62'(focal_length);
    side6 <= side5;
  end

  // stage 7: radius squared against f squared
  logic [62:0] num_c, num7;
  logic [61:0] den7;
  side_t side7_c;
  side_t side7;
  logic v7;
  assign num_c = 63'(xs6) + 63'(ys6);

  always_comb begin
    side7_c         = side6;
    side7_c.outside = side6.outside || (num_c > 63'(den6));
  end

  always_ff @(posedge clk) begin
    v7    <= rst ? 1'b0 : v6;
    num7  <= num_c;
    den7  <= den6;
    side7 <= side7_c;
  end

  // tau divider: integer step, then one fraction bit a stage
  logic [62:0] td_r [1:31];
  logic [30:0] td_q [1:31];
  logic [61:0] td_d [1:31];
  side_t       td_s [1:31];
  logic        td_v [1:31];

  for (genvar j = 1; j <= 31; j++) begin : g_tdiv
    logic [62:0] rin, rsh;
    logic [30:0] qin;
    logic [61:0] din;
    side_t       sin;
    logic        vin;
    if (j == 1) begin : g_first
      assign rin = num7;
      assign qin = '0;
      assign din = den7;
      assign sin = side7;
      assign vin = v7;
      assign rsh = rin;
    end else begin : g_next
      assign rin = td_r[j-1];
      assign qin = td_q[j-1];
      assign din = td_d[j-1];
      assign sin = td_s[j-1];
      assign vin = td_v[j-1];
      assign rsh = {rin[61:0], 1'b0};
    end
    always_ff @(posedge clk) begin
      td_v[j] <= rst ? 1'b0 : vin;
      td_d[j] <= din;
      td_s[j] <= sin;
      if (rsh >= 63'(din)) begin
        td_r[j] <= rsh - 63'(din);
        td_q[j] <= {qin[29:0], 1'b1};
      end else begin
        td_r[j] <= rsh;
        td_q[j] <= {qin[29:0], 1'b0};
      end
    end
  end

  // square root of (1 - tau) in Q30, one result bit a stage
  logic [61:0] sq_v   [0:30];
  logic [61:0] sq_r   [0:30];
  logic [30:0] sq_tau [0:30];
  logic [30:0] sq_u   [0:30];
  side_t       sq_s   [0:30];
  logic        sq_vd  [0:30];
  logic [30:0] u_c;
  assign u_c = ONE31 - td_q[31];

  for (genvar i = 0; i <= 30; i++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'(1) << (60 - 2 * i);
    logic [61:0] vin, rin, trial;
    logic [30:0] tin, uin;
    side_t       sin;
    logic        vdin;
    if (i == 0) begin : g_first
      assign vin  = {1'b0, u_c, 30'b0};
      assign rin  = '0;
      assign tin  = td_q[31];
      assign uin  = u_c;
      assign sin  = td_s[31];
      assign vdin = td_v[31];
    end else begin : g_next
      assign vin  = sq_v[i-1];
      assign rin  = sq_r[i-1];
      assign tin  = sq_tau[i-1];
      assign uin  = sq_u[i-1];
      assign sin  = sq_s[i-1];
      assign vdin = sq_vd[i-1];
    end
    assign trial = rin + BIT;
    always_ff @(posedge clk) begin
      sq_vd[i]  <= rst ? 1'b0 : vdin;
      sq_tau[i] <= tin;
      sq_u[i]   <= uin;
      sq_s[i]   <= sin;
      if (vin >= trial) begin
        sq_v[i] <= vin - trial;
        sq_r[i] <= (rin >> 1) + BIT;
      end else begin
        sq_v[i] <= vin;
        sq_r[i] <= rin >> 1;
      end
    end
  end

  // P1: a = 171 + 73 s, t = 1 + s
  logic [30:0] s_c;
  logic [38:0] a1;
  logic [31:0] t1;
  logic [30:0] s1r, u1, tau1;
  side_t side_p1;
  logic vp1;
  assign s_c = sq_r[30][30:0];

  always_ff @(posedge clk) begin
    vp1     <= rst ? 1'b0 : sq_vd[30];
    a1      <= K171 + 39'(73) * 39'(s_c);
    t1      <= ONE32 + 32'(s_c);
    s1r     <= s_c;
    u1      <= sq_u[30];
    tau1    <= sq_tau[30];
    side_p1 <= sq_s[30];
  end

  // P2: u * a split, t squared
  logic [49:0] ua_hi2;
  logic [50:0] ua_lo2;
  logic [63:0] tt2;
  logic [30:0] s2r, tau2;
  logic [31:0] t2;
  side_t side_p2;
  logic vp2;
  always_ff @(posedge clk) begin
    vp2     <= rst ? 1'b0 : vp1;
    ua_hi2  <= 50'(u1) * 50'(a1[38:20]);
    ua_lo2  <= 51'(u1) * 51'(a1[19:0]);
    tt2     <= 64'(t1) * 64'(t1);
    s2r     <= s1r;
    tau2    <= tau1;
    t2      <= t1;
    side_p2 <= side_p1;
  end

  // P3: numerator polynomial, t^2 in Q30
  logic [69:0] ua_sum;
  logic [39:0] n3;
  logic [33:0] tsq3;
  logic [31:0] t3;
  logic [30:0] tau3;
  side_t side_p3;
  logic vp3;
  assign ua_sum = (70'(ua_hi2) << 20) + 70'(ua_lo2);

  always_ff @(posedge clk) begin
    vp3     <= rst ? 1'b0 : vp2;
    n3      <= K47 + 40'(141) * 40'(s2r) + ua_sum[69:30];
    tsq3    <= tt2[63:30];
    t3      <= t2;
    tau3    <= tau2;
    side_p3 <= side_p2;
  end

  // P4: tau * n split, t^3
  logic [50:0] top_hi4, top_lo4;
  logic [65:0] tcu4;
  side_t side_p4;
  logic vp4;
  always_ff @(posedge clk) begin
    vp4     <= rst ? 1'b0 : vp3;
    top_hi4 <= 51'(tau3) * 51'(n3[39:20]);
    top_lo4 <= 51'(tau3) * 51'(n3[19:0]);
    tcu4    <= 66'(t3) * 66'(tsq3);
    side_p4 <= side_p3;
  end

  // P5: fold partial products
  logic [70:0] top_sum;
  logic [40:0] top5;
  logic [35:0] tcu5;
  side_t side_p5;
  logic vp5;
  assign top_sum = (71'(top_hi4) << 20) + 71'(top_lo4);

  always_ff @(posedge clk) begin
    vp5     <= rst ? 1'b0 : vp4;
    top5    <= top_sum[70:30];
    tcu5    <= tcu4[65:30];
    side_p5 <= side_p4;
  end

  // P6: divisor 486 (1 + s)^3
  logic [43:0] rem6, d6;
  side_t side_p6;
  logic vp6;
  always_ff @(posedge clk) begin
    vp6     <= rst ? 1'b0 : vp5;
    d6      <= 44'(45'(486) * 45'(tcu5));
    rem6    <= 44'(top5);
    side_p6 <= side_p5;
  end

  // surface divider, one fraction bit a stage
  logic [43:0] fd_r [1:30];
  logic [29:0] fd_q [1:30];
  logic [43:0] fd_d [1:30];
  side_t       fd_s [1:30];
  logic        fd_v [1:30];

  for (genvar j = 1; j <= 30; j++) begin : g_fdiv
    logic [43:0] rin, din, rsh;
    logic [29:0] qin;
    side_t       sin;
    logic        vin;
    if (j == 1) begin : g_first
      assign rin = rem6;
      assign qin = '0;
      assign din = d6;
      assign sin = side_p6;
      assign vin = vp6;
    end else begin : g_next
      assign rin = fd_r[j-1];
      assign qin = fd_q[j-1];
      assign din = fd_d[j-1];
      assign sin = fd_s[j-1];
      assign vin = fd_v[j-1];
    end
    assign rsh = {rin[42:0], 1'b0};
    always_ff @(posedge clk) begin
      fd_v[j] <= rst ? 1'b0 : vin;
      fd_d[j] <= din;
      fd_s[j] <= sin;
      if (rsh >= din) begin
        fd_r[j] <= rsh - din;
        fd_q[j] <= {qin[28:0], 1'b1};
      end else begin
        fd_r[j] <= rsh;
        fd_q[j] <= {qin[28:0], 1'b0};
      end
    end
  end

  // F1: f * F(tau)
  logic [60:0] zp_prod;
  logic [30:0] zp1;
  side_t side_f1;
  logic vf1;
  assign zp_prod = 61'(fd_q[30]) * 61'(focal_length);

  always_ff @(posedge clk) begin
    vf1     <= rst ? 1'b0 : fd_v[30];
    zp1     <= zp_prod[60:30];
    side_f1 <= fd_s[30];
  end

  // F2: residual and output beat
  always_ff @(posedge clk) begin
    done            <= rst ? 1'b0 : vf1;
    moved_x         <= side_f1.mx;
    moved_y         <= side_f1.my;
    out_of_aperture <= side_f1.outside;
    residual_z      <= side_f1.outside ? '0 :
                       sat_coord(side_f1.z2 - EXT_W'(zp1));
  end

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result beat without a matching input beat");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_aperture) |-> (residual_z == '0))
    else $error("residual not zero outside aperture");

  a_always_open: assert property (@(posedge clk)
    cfg_ready && !busy)
    else $error("block refused a beat");

endmodule
